### hw/rtl/cap_button_key_report_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the capacitive button key report generator
// Shared property wrappers, clocked on clk and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef CAP_BUTTON_KEY_REPORT_GENERATOR_CORE_ASSERT_SVH
`define CAP_BUTTON_KEY_REPORT_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define CBKRG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBKRG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/cbkrg_pkg.sv
// ----------------------------------------------------------------------------
// cbkrg_pkg
// Types and constants of the capacitive button key report generator
// ----------------------------------------------------------------------------
package cbkrg_pkg;

	localparam int NumButtons = 3;
	localparam int MaxReports = 5;
	localparam int CntW       = $clog2(MaxReports + 1);

	localparam logic KindKeyboard = 1'b0;
	localparam logic KindConsumer = 1'b1;

	localparam logic [2:0] KeyNone    = 3'd0;
	localparam logic [2:0] KeyButton1 = 3'd1;
	localparam logic [2:0] KeyTab     = 3'd2;
	localparam logic [2:0] KeyAlt     = 3'd4;
	localparam logic [2:0] ConsButton0 = 3'd1;
	localparam logic [2:0] ConsButton2 = 3'd2;

	localparam logic [15:0] LongPressReset = 16'd1500;

	typedef enum logic [1:0] {
		REG_BUTTONS_PRESENT  = 2'd0,
		REG_REVERSED_ORDER   = 2'd1,
		REG_LONG_PRESS_TICKS = 2'd2
	} cfg_reg_e;

	localparam logic ActionSample = 1'b0;
	localparam logic ActionTick   = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] raw_buttons;
	} in_item_t;

	typedef struct packed {
		logic       report_kind;
		logic [2:0] key_bits;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic       kind;
		logic [2:0] keys;
	} rpt_t;

endpackage

### hw/rtl/cap_button_key_report_generator_core.sv
// ----------------------------------------------------------------------------
// cap_button_key_report_generator_core
// Turns button samples and millisecond ticks into keyboard and consumer reports
// ----------------------------------------------------------------------------
// An input transaction is registered, then evaluated combinationally against
// the button state; its reports (zero to five) are loaded into a five-entry
// report buffer that drains one report per cycle while report_ready is high.
// A transaction that produces no report leaves the input stage without
// waiting on the buffer, so such items flow at one per cycle. A transaction
// with reports holds the input stage until the buffer is empty or its last
// report is taken, and advances in that cycle. Configuration writes take
// effect on the next cycle.
`include "cap_button_key_report_generator_core_assert.svh"

module cap_button_key_report_generator_core
	import cbkrg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic       item_valid,
	output logic       item_ready,
	input  in_item_t   item,
	output logic       report_valid,
	input  logic       report_ready,
	output out_item_t  report
);

	logic                  present_q;
	logic                  reversed_q;
	logic [15:0]           ticks_q;

	logic                  valid_s1;
	in_item_t              item_s1;

	logic [NumButtons-1:0] prev_q;
	logic [NumButtons-1:0] pend_q;
	logic [15:0]           cd_q;
	logic                  run_q;

	rpt_t                  buf_q [MaxReports];
	logic [CntW-1:0]       cnt_q;

	logic [NumButtons-1:0] mapped;
	logic [NumButtons-1:0] pressed;
	logic [NumButtons-1:0] released;
	logic [NumButtons-1:0] next_prev;
	logic [NumButtons-1:0] next_pend;
	logic [15:0]           next_cd;
	logic                  next_run;
	logic                  b0;
	logic                  b2;
	rpt_t                  list [MaxReports];
	logic [CntW-1:0]       n_res;

	logic                  pop;
	logic                  buf_free;
	logic                  advance;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= 1'b1;
			reversed_q <= 1'b0;
			ticks_q    <= LongPressReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_BUTTONS_PRESENT:  present_q  <= cfg_data[0];
				REG_REVERSED_ORDER:   reversed_q <= cfg_data[0];
				REG_LONG_PRESS_TICKS: ticks_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pop      = (cnt_q != '0) && report_ready;
	assign buf_free = (cnt_q == '0) || ((cnt_q == CntW'(1)) && report_ready);
	assign advance  = valid_s1 && (buf_free || (n_res == '0));
	assign item_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// raw bit to button mapping
	always_comb begin
		for (int i = 0; i < NumButtons; i++) begin
			mapped[i] = reversed_q ? item_s1.raw_buttons[i]
				: item_s1.raw_buttons[NumButtons-1-i];
		end
	end

	assign pressed  = mapped & ~prev_q;
	assign released = prev_q & ~mapped;

	// evaluation of one transaction
	always_comb begin
		next_prev = prev_q;
		next_pend = pend_q;
		next_cd   = cd_q;
		next_run  = run_q;
		n_res     = '0;
		b0        = 1'b0;
		b2        = 1'b0;
		for (int i = 0; i < MaxReports; i++) begin
			list[i] = '{kind: KindKeyboard, keys: KeyNone};
		end
		if (item_s1.action == ActionTick) begin
			if (run_q) begin
				if (cd_q > 16'd1) begin
					next_cd = cd_q - 16'd1;
				end else begin
					next_cd  = '0;
					next_run = 1'b0;
					if (present_q && pend_q[2]) begin
						list[0]      = '{kind: KindKeyboard, keys: KeyAlt | KeyTab};
						list[1]      = '{kind: KindKeyboard, keys: KeyAlt};
						n_res        = CntW'(2);
						next_pend[2] = 1'b0;
					end
				end
			end
		end else if (present_q) begin
			if (pressed != '0) begin
				next_pend = next_pend | pressed;
				next_cd   = ticks_q;
				next_run  = 1'b1;
			end
			if (released[1]) begin
				if (next_pend[1]) begin
					list[n_res] = '{kind: KindKeyboard, keys: KeyButton1};
					n_res       = n_res + CntW'(1);
				end
				list[n_res]  = '{kind: KindKeyboard, keys: KeyNone};
				n_res        = n_res + CntW'(1);
				next_pend[1] = 1'b0;
			end
			b0 = released[0] && next_pend[0];
			b2 = released[2] && next_pend[2];
			if (b0 || b2) begin
				list[n_res] = '{kind: KindConsumer,
					keys: (b0 ? ConsButton0 : KeyNone) | (b2 ? ConsButton2 : KeyNone)};
				n_res        = n_res + CntW'(1);
				list[n_res]  = '{kind: KindConsumer, keys: KeyNone};
				n_res        = n_res + CntW'(1);
				next_pend[0] = 1'b0;
				next_pend[2] = 1'b0;
			end
			if (released[2] && !next_pend[2]) begin
				list[n_res] = '{kind: KindKeyboard, keys: KeyNone};
				n_res       = n_res + CntW'(1);
			end
			next_prev = mapped;
		end
	end

	// button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			pend_q <= '0;
			cd_q   <= '0;
			run_q  <= 1'b0;
		end else if (advance) begin
			prev_q <= next_prev;
			pend_q <= next_pend;
			cd_q   <= next_cd;
			run_q  <= next_run;
		end
	end

	// report buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance && (n_res != '0)) begin
			cnt_q <= n_res;
		end else if (pop) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (n_res != '0)) begin
			for (int i = 0; i < MaxReports; i++) begin
				buf_q[i] <= list[i];
			end
		end else if (pop) begin
			for (int i = 0; i < MaxReports - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	assign report_valid       = (cnt_q != '0);
	assign report.report_kind = buf_q[0].kind;
	assign report.key_bits    = buf_q[0].keys;
	assign report.last        = (cnt_q == CntW'(1));

	`CBKRG_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CntW'(MaxReports), "report count out of range")
	`CBKRG_ASSERT_NOW(a_cd_idle, !run_q, cd_q == '0, "countdown nonzero while stopped")
	`CBKRG_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(item_s1), "stalled transaction lost")

endmodule

### dv/tb_cap_button_key_report_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cap_button_key_report_generator_core
// Self-checking bench for the capacitive button key report generator. A
// directed table of samples, ticks and register writes comes first, then
// random press, hold and release traffic over several register settings.
// Each report is checked against a directed row's list or an in-bench model
// of the button, pending flag and long-press logic. Bursty input, stalling sink.
// ----------------------------------------------------------------------------
module tb_cap_button_key_report_generator_core;
	import cbkrg_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 8;
	localparam int HoldCycles  = 300;
	localparam out_item_t NoRpt = '0;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;
	typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SLOW} sink_mode_e;
	typedef out_item_t [0:4] rpt_set_t;

	typedef struct packed {
		row_op_e     op;
		in_item_t    stim;
		cfg_reg_e    reg_idx;
		logic [15:0] reg_val;
		logic        typed;
		logic [2:0]  n_typed;
		rpt_set_t    typed_rpts;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        item_valid;
	logic        item_ready;
	in_item_t    item;
	logic        report_valid;
	logic        report_ready;
	out_item_t   report;

	// model copy of registers and button state
	logic        model_present  = 1'b1;
	logic        model_reversed = 1'b0;
	logic [15:0] model_ticks    = LongPressReset;
	logic [7:0]  btn_prev       = '0;
	logic [7:0]  btn_pending    = '0;
	logic [15:0] lp_count       = '0;
	logic        lp_armed       = 1'b0;

	out_item_t step_reports[$];
	out_item_t expected_reports[$];

	int mismatches   = 0;
	int reports_seen = 0;
	int cycles       = 0;
	int burst_left   = 0;

	cap_button_key_report_generator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic out_item_t rpt(logic kind, logic [2:0] keys, logic fin);
		out_item_t r;
		r.report_kind = kind;
		r.key_bits    = keys;
		r.last        = fin;
		return r;
	endfunction

	function automatic dir_row_t row_chk(logic act, logic [7:0] raw, int n, rpt_set_t want);
		dir_row_t r;
		r = '0;
		r.op               = ROW_ITEM;
		r.stim.action      = act;
		r.stim.raw_buttons = raw;
		r.typed            = 1'b1;
		r.n_typed          = n[2:0];
		r.typed_rpts       = want;
		return r;
	endfunction

	function automatic dir_row_t row_item(logic act, logic [7:0] raw);
		dir_row_t r;
		r = row_chk(act, raw, 0, '0);
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic dir_row_t row_cfg(cfg_reg_e idx, logic [15:0] val);
		dir_row_t r;
		r = '0;
		r.op      = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic void predict_reports(in_item_t x);
		logic [7:0] now_b;
		logic [7:0] pressed;
		logic [7:0] released;
		logic       b0;
		logic       b2;
		int         pos;
		out_item_t  tail;
		step_reports.delete();
		if (x.action == ActionTick) begin
			if (lp_armed) begin
				if (lp_count > 16'd1) begin
					lp_count = lp_count - 16'd1;
				end else begin
					lp_count = '0;
					lp_armed = 1'b0;
					if (model_present && btn_pending[2]) begin
						step_reports.push_back(rpt(KindKeyboard, KeyAlt | KeyTab, 1'b0));
						step_reports.push_back(rpt(KindKeyboard, KeyAlt, 1'b0));
						btn_pending[2] = 1'b0;
					end
				end
			end
		end else if (model_present) begin
			now_b = '0;
			for (int i = 0; i < NumButtons; i++) begin
				pos = model_reversed ? i : NumButtons - 1 - i;
				now_b[i] = x.raw_buttons[pos];
			end
			pressed  = now_b & ~btn_prev;
			released = btn_prev & ~now_b;
			if (pressed != '0) begin
				btn_pending = btn_pending | pressed;
				lp_count    = model_ticks;
				lp_armed    = 1'b1;
			end
			if (released[1]) begin
				if (btn_pending[1])
					step_reports.push_back(rpt(KindKeyboard, KeyButton1, 1'b0));
				step_reports.push_back(rpt(KindKeyboard, KeyNone, 1'b0));
				btn_pending[1] = 1'b0;
			end
			b0 = released[0] && btn_pending[0];
			b2 = released[2] && btn_pending[2];
			if (b0 || b2) begin
				step_reports.push_back(rpt(KindConsumer,
					(b0 ? ConsButton0 : KeyNone) | (b2 ? ConsButton2 : KeyNone), 1'b0));
				step_reports.push_back(rpt(KindConsumer, KeyNone, 1'b0));
				btn_pending[0] = 1'b0;
				btn_pending[2] = 1'b0;
			end
			if (released[2] && !btn_pending[2])
				step_reports.push_back(rpt(KindKeyboard, KeyNone, 1'b0));
			btn_prev = now_b;
		end
		if (step_reports.size() != 0) begin
			tail = step_reports.pop_back();
			tail.last = 1'b1;
			step_reports.push_back(tail);
		end
	endfunction

	// bursts of random length, mostly followed by a gap with item_valid low
	task automatic pace();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
	endtask

	task automatic offer(in_item_t x, logic typed, logic [2:0] n_typed, rpt_set_t want);
		item       <= x;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		predict_reports(x);
		if (typed) begin
			for (int k = 0; k < n_typed; k++)
				expected_reports.push_back(want[k]);
		end else begin
			foreach (step_reports[k])
				expected_reports.push_back(step_reports[k]);
		end
		@(negedge clk);
		pace();
	endtask

	// registers change only with the block drained
	task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
		item_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_BUTTONS_PRESENT:  model_present  = val[0];
			REG_REVERSED_ORDER:   model_reversed = val[0];
			REG_LONG_PRESS_TICKS: model_ticks    = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : report_check
		out_item_t want;
		if (arst_n && report_valid && report_ready) begin
			reports_seen++;
			if (expected_reports.size() == 0) begin
				$display("%0t: report with none expected, actual kind %0d keys %0d last %0d",
					$time, report.report_kind, report.key_bits, report.last);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				check_field("report_kind", want.report_kind, report.report_kind);
				check_field("key_bits", want.key_bits, report.key_bits);
				check_field("last", want.last, report.last);
			end
		end
	end

	initial begin : report_sink
		sink_mode_e mode;
		int         seg_left;
		bit         hold_done;
		mode         = SINK_OPEN;
		seg_left     = 0;
		hold_done    = 1'b0;
		report_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!hold_done && reports_seen >= 30) begin
				hold_done = 1'b1;
				report_ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			if (seg_left == 0) begin
				mode     = sink_mode_e'($urandom_range(0, 2));
				seg_left = $urandom_range(10, 60);
			end
			seg_left--;
			case (mode)
				SINK_OPEN:   report_ready <= 1'b1;
				SINK_RANDOM: report_ready <= 1'($urandom_range(0, 1));
				default:     report_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("cap_button_key_report_generator_core verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t   dir_table[$];
		in_item_t   x;
		logic [7:0] held;
		int         pick;
		int         flip;
		cfg_we     = 1'b0;
		cfg_index  = REG_BUTTONS_PRESENT;
		cfg_data   = '0;
		item_valid = 1'b0;
		item       = '0;
		arst_n     = 1'b0;
		dir_table = '{
			// power-up settings: mirrored bit order, long press 1500
			row_chk(ActionTick, 8'h00, 0, '0),
			row_chk(ActionSample, 8'h04, 0, '0),
			row_chk(ActionSample, 8'h00, 2, {rpt(KindConsumer, ConsButton0, 1'b0),
				rpt(KindConsumer, KeyNone, 1'b1), NoRpt, NoRpt, NoRpt}),
			row_chk(ActionSample, 8'hFF, 0, '0),
			// all three released while pending
			row_chk(ActionSample, 8'h00, 5, {rpt(KindKeyboard, KeyButton1, 1'b0),
				rpt(KindKeyboard, KeyNone, 1'b0),
				rpt(KindConsumer, ConsButton0 | ConsButton2, 1'b0),
				rpt(KindConsumer, KeyNone, 1'b0), rpt(KindKeyboard, KeyNone, 1'b1)}),
			row_cfg(REG_REVERSED_ORDER, 16'd1),
			row_cfg(REG_LONG_PRESS_TICKS, 16'd0),
			row_chk(ActionSample, 8'h04, 0, '0),
			row_chk(ActionTick, 8'h00, 2, {rpt(KindKeyboard, KeyAlt | KeyTab, 1'b0),
				rpt(KindKeyboard, KeyAlt, 1'b1), NoRpt, NoRpt, NoRpt}),
			row_chk(ActionSample, 8'h00, 1, {rpt(KindKeyboard, KeyNone, 1'b1),
				NoRpt, NoRpt, NoRpt, NoRpt}),
			row_chk(ActionTick, 8'hFF, 0, '0),
			row_cfg(REG_LONG_PRESS_TICKS, 16'd1),
			row_item(ActionSample, 8'h02),
			// expiry with button 2 not pending
			row_chk(ActionTick, 8'h00, 0, '0),
			row_chk(ActionSample, 8'h00, 2, {rpt(KindKeyboard, KeyButton1, 1'b0),
				rpt(KindKeyboard, KeyNone, 1'b1), NoRpt, NoRpt, NoRpt}),
			row_cfg(REG_LONG_PRESS_TICKS, 16'd3),
			row_item(ActionSample, 8'h01),
			row_item(ActionTick, 8'h00),
			row_item(ActionSample, 8'h05),
			row_item(ActionTick, 8'h00),
			row_item(ActionTick, 8'h00),
			row_item(ActionTick, 8'h00),
			row_item(ActionSample, 8'h00),
			row_cfg(REG_LONG_PRESS_TICKS, 16'd1),
			row_item(ActionSample, 8'hFC),
			// expiry with buttons absent keeps the pending flag
			row_cfg(REG_BUTTONS_PRESENT, 16'd0),
			row_chk(ActionTick, 8'h00, 0, '0),
			row_chk(ActionSample, 8'h07, 0, '0),
			row_chk(ActionTick, 8'h00, 0, '0),
			row_cfg(REG_BUTTONS_PRESENT, 16'd1),
			row_cfg(REG_LONG_PRESS_TICKS, 16'hFFFF),
			row_item(ActionSample, 8'h00)
		};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_table[r]) begin
			if (dir_table[r].op == ROW_CFG)
				write_reg(dir_table[r].reg_idx, dir_table[r].reg_val);
			else
				offer(dir_table[r].stim, dir_table[r].typed, dir_table[r].n_typed,
					dir_table[r].typed_rpts);
		end
		held = '0;
		for (int ph = 0; ph < 9; ph++) begin
			write_reg(REG_BUTTONS_PRESENT, (ph == 3) ? 16'd0 : 16'd1);
			write_reg(REG_REVERSED_ORDER, 16'($urandom_range(0, 1)));
			case ($urandom_range(0, 6))
				0:       pick = 0;
				1:       pick = 1;
				2:       pick = 65535;
				default: pick = $urandom_range(2, 6);
			endcase
			write_reg(REG_LONG_PRESS_TICKS, pick[15:0]);
			for (int k = 0; k < 20; k++) begin
				pick = $urandom_range(0, 9);
				x.action      = (pick < 4) ? ActionTick : ActionSample;
				x.raw_buttons = {5'($urandom_range(0, 31)), held[2:0]};
				if (pick >= 6 && pick < 9) begin
					flip = $urandom_range(0, 2);
					x.raw_buttons[flip] = ~x.raw_buttons[flip];
				end else if (pick == 9) begin
					x.raw_buttons = 8'($urandom_range(0, 255));
				end
				if (x.action == ActionSample)
					held = x.raw_buttons;
				offer(x, 1'b0, 3'd0, '0);
			end
		end
		item_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("cap_button_key_report_generator_core verification clean");
		else
			$display("cap_button_key_report_generator_core verification failed");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cbkrg_pkg.sv
hw/rtl/cap_button_key_report_generator_core.sv
dv/tb_cap_button_key_report_generator_core.sv
